// ===== design/lcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Liveness monitor package
// Shared types and constants for the channel cells, divider and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lcm_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int IDX_W        = 6;    // enough for the largest channel count

    // Function codes of an input request
    localparam logic [2:0] FN_HEARTBEAT = 3'd0;
    localparam logic [2:0] FN_CHECK     = 3'd1;
    localparam logic [2:0] FN_ENABLE    = 3'd2;
    localparam logic [2:0] FN_DISABLE   = 3'd3;
    localparam logic [2:0] FN_CONFIGURE = 3'd4;
    localparam logic [2:0] FN_START     = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_FATAL_LEVEL = 2'd0;
    localparam logic [1:0] REG_LED_CYCLE   = 2'd1;
    localparam logic [1:0] REG_LED_BLINK   = 2'd2;
    localparam logic [1:0] REG_HB_PERIOD   = 2'd3;

    localparam logic [15:0] LED_CYCLE_RST = 16'd3000;
    localparam logic [15:0] LED_BLINK_RST = 16'd1000;
    localparam logic [15:0] HB_PERIOD_RST = 16'd1000;
    localparam logic [7:0]  LEVEL_NONE    = 8'hFF;

    // Broadcast strobes from the sequencer to every cell
    typedef struct packed {
        logic start;
        logic hb;
        logic en;
        logic dis;
        logic cfg;
        logic eval;
        logic commit;
        logic trip;
    } ctl_t;

    // Fields of the accepted request, channel in the lowest bits
    typedef struct packed {
        logic        enable_bit;
        logic [3:0]  group;
        logic [7:0]  level;
        logic [31:0] timeout_ms;
        logic [31:0] now;
        logic [3:0]  channel;
    } item_t;

    // Scan accumulator handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             any_off;
        logic [7:0]       min_level;
        logic             fatal_hit;
        logic [3:0]       fatal_ch;
        logic [3:0]       best_group;
        logic [IDX_W-1:0] disp;
    } acc_t;

endpackage

`default_nettype wire

// ===== design/lcm_cell.sv =====
// ----------------------------------------------------------------------------
// Liveness monitor channel cell
// Holds one channel's table entry and folds it into the passing scan token.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm_cell
    import lcm_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctl_t       ctl,
    input  wire item_t      item,
    input  wire logic [7:0] fatal_level,
    input  wire acc_t       acc_in,
    output acc_t            acc_out,
    output logic [1:0]      kind,
    output logic            en_out
);

    localparam logic [IDX_W-1:0] IDX_V = IDX_W'(IDX);

    logic [31:0] last_seen_reg;
    logic [31:0] timeout_reg;
    logic [7:0]  level_reg;
    logic [3:0]  group_reg;
    logic        enabled_reg;
    logic        off_now_reg;
    logic        off_before_reg;
    logic [1:0]  kind_reg;
    acc_t        acc_reg;
    acc_t        acc_next;
    logic        hit;
    logic        silent;
    logic [31:0] silence;

    assign hit     = ({2'b00, item.channel} == IDX_V);
    assign silence = item.now - last_seen_reg;
    assign silent  = enabled_reg && (silence > timeout_reg);

    // Fold this channel into the token; the protect channel does not count
    always_comb
    begin
        acc_next = acc_in;
        if (IDX != 0 && off_now_reg)
        begin
            acc_next.any_off = 1'b1;
            if (level_reg < acc_in.min_level)
                acc_next.min_level = level_reg;
            if (level_reg == fatal_level)
            begin
                acc_next.fatal_hit = 1'b1;
                acc_next.fatal_ch  = IDX_V[3:0];
            end
            if (group_reg > acc_in.best_group)
            begin
                acc_next.best_group = group_reg;
                acc_next.disp       = IDX_V;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seen_reg  <= '0;
            timeout_reg    <= '0;
            level_reg      <= '0;
            group_reg      <= '0;
            enabled_reg    <= 1'b0;
            off_now_reg    <= 1'b0;
            off_before_reg <= 1'b0;
            kind_reg       <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            acc_reg <= acc_in.valid ? acc_next : '0;
            if (ctl.start)
            begin
                last_seen_reg  <= item.now;
                off_now_reg    <= 1'b0;
                off_before_reg <= 1'b0;
            end
            if (hit && ctl.hb)
                last_seen_reg <= item.now;
            if (hit && ctl.en)
                enabled_reg <= 1'b1;
            if (hit && ctl.dis)
                enabled_reg <= 1'b0;
            if (hit && ctl.cfg)
            begin
                timeout_reg <= item.timeout_ms;
                level_reg   <= item.level;
                group_reg   <= item.group;
                enabled_reg <= item.enable_bit;
            end
            if (ctl.eval && IDX != 0)
                off_now_reg <= silent;
            if (ctl.commit)
            begin
                if (IDX == 0)
                begin
                    off_now_reg    <= ctl.trip;
                    kind_reg       <= {ctl.trip, off_before_reg};
                    off_before_reg <= ctl.trip;
                end
                else if (!ctl.trip)
                begin
                    kind_reg       <= {off_now_reg, off_before_reg};
                    off_before_reg <= off_now_reg;
                end
            end
        end
    end

    assign acc_out = acc_reg;
    assign kind    = kind_reg;
    assign en_out  = enabled_reg;

endmodule

`default_nettype wire

// ===== design/lcm_div.sv =====
// ----------------------------------------------------------------------------
// Liveness monitor divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm_div
    import lcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quo,
    output logic [31:0]      rem
);

    logic [31:0] dvd_reg;
    logic [31:0] dvs_reg;
    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg[31:0], dvd_reg[31]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= fits ? (trial - {1'b0, dvs_reg}) : trial;
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg[31:0];

endmodule

`default_nettype wire

// ===== design/multi_channel_liveness_monitor.sv =====
// ----------------------------------------------------------------------------
// Multi-channel liveness monitor
// Per-channel heartbeat timeout monitor with blink-coded offline LED.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser / tlast
//  s_axis  | in        | channel,now,timeout_ms,level,group,enable_bit / func / -
//  m_axis  | out       | report_channel,leds,display,fatal,protect / kind / last
//  cfg     | in        | cfg_we, cfg_addr (register index), cfg_data
//
//  Non-check requests leave the monitor ready. A check holds in the scan
//  while the token passes the row of cells, then, when an offline channel
//  has a group, one or three divisions in the shared divider for the LED
//  pattern, then one result per cycle (1, or min(CHANNELS,16)) while
//  m_tready is high.
//  Reset clears the whole channel table at once (no clearing pass).
//  A stall on the output holds the result and blocks new requests.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_liveness_monitor
    import lcm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] channel, [35:4] now, [67:36] timeout_ms, [75:68] level,
    // [79:76] group, [80] enable_bit, [87:81] zero
    input  wire logic [87:0] s_tdata,
    input  wire logic [2:0]  s_tuser,   // [2:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] report_channel, [4] offline_led, [5] heartbeat_led,
    // [9:6] display_channel, [13:10] fatal_channel, [14] protect_tripped,
    // [15] zero
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_data
);

    localparam int NREP = (CHANNELS < 16) ? CHANNELS : 16;
    localparam logic [3:0] LAST_K = 4'(NREP - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_CYC  = 6'b000100,
        S_HALF = 6'b001000,
        S_PH   = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t      state_reg;
    state_t      state_next;

    // Configuration registers
    logic [7:0]  fatal_level_reg;
    logic [15:0] led_cycle_reg;
    logic [15:0] led_blink_reg;
    logic [15:0] hb_period_reg;

    // Check state
    logic [3:0]  fatal_store_reg;
    logic [31:0] last_toggle_reg;
    logic        hb_level_reg;
    logic        oled_reg;
    logic        trip_reg;
    logic [3:0]  disp_reg;
    logic [3:0]  group_reg;
    logic [31:0] now_reg;
    logic [31:0] phase_reg;
    logic [3:0]  k_reg;
    logic        inject_reg;

    item_t       item;
    ctl_t        ctl;
    logic        accept;
    logic        out_fire;
    logic        out_last;

    acc_t        acc_w [CHANNELS+1];
    logic [1:0]  kind_c [CHANNELS];
    logic [1:0]  kind_w [16];
    logic [CHANNELS-1:0] en_w;
    acc_t        tail;
    logic        trip;

    // Divider hookup
    logic        div_start;
    logic [31:0] div_a;
    logic [31:0] div_b;
    logic        div_done;
    logic [31:0] div_q;
    logic [31:0] div_r;
    logic [31:0] half;

    assign item = s_tdata[80:0];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign tail     = acc_w[CHANNELS];
    assign trip     = tail.any_off && (tail.min_level == fatal_level_reg) && en_w[0];

    // Decode the request into broadcast strobes
    always_comb
    begin
        ctl        = '0;
        ctl.start  = accept && (s_tuser == FN_START);
        ctl.hb     = accept && (s_tuser == FN_HEARTBEAT);
        ctl.en     = accept && (s_tuser == FN_ENABLE);
        ctl.dis    = accept && (s_tuser == FN_DISABLE);
        ctl.cfg    = accept && (s_tuser == FN_CONFIGURE);
        ctl.eval   = accept && (s_tuser == FN_CHECK);
        ctl.commit = (state_reg == S_SCAN) && tail.valid;
        ctl.trip   = trip;
    end

    // Fresh token enters the first cell in the cycle after the check request
    assign acc_w[0] = {inject_reg, 1'b0, LEVEL_NONE, 1'b0, 4'd0, 4'd0,
                       {IDX_W{1'b0}}};

    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++)
        begin : g_cell
            lcm_cell #(.IDX(gi)) u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .item        (item),
                .fatal_level (fatal_level_reg),
                .acc_in      (acc_w[gi]),
                .acc_out     (acc_w[gi+1]),
                .kind        (kind_c[gi]),
                .en_out      (en_w[gi])
            );
        end
        for (gi = 0; gi < 16; gi++)
        begin : g_kind
            if (gi < CHANNELS)
            begin : g_real
                assign kind_w[gi] = kind_c[gi];
            end
            else
            begin : g_pad
                assign kind_w[gi] = 2'd0;
            end
        end
    endgenerate

    assign half = (div_q == 32'd0) ? 32'd1 : div_q;

    lcm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quo      (div_q),
        .rem      (div_r)
    );

    // Sequencer and divider operand selection
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_a      = now_reg;
        div_b      = {16'd0, (led_cycle_reg == 16'd0) ? 16'd1 : led_cycle_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.eval)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    if (tail.disp != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = S_CYC;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_CYC:
            begin
                div_a = {16'd0, led_blink_reg};
                div_b = {27'd0, group_reg, 1'b0};
                if (div_done)
                begin
                    if (div_r >= {16'd0, led_blink_reg})
                        state_next = S_OUT;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_HALF;
                    end
                end
            end
            S_HALF:
            begin
                div_a = phase_reg;
                div_b = half;
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_PH;
                end
            end
            S_PH:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire && out_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fatal_level_reg <= '0;
            led_cycle_reg   <= LED_CYCLE_RST;
            led_blink_reg   <= LED_BLINK_RST;
            hb_period_reg   <= HB_PERIOD_RST;
            fatal_store_reg <= '0;
            last_toggle_reg <= '0;
            hb_level_reg    <= 1'b0;
            inject_reg      <= 1'b0;
            k_reg           <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= ctl.eval;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_FATAL_LEVEL: fatal_level_reg <= cfg_data[7:0];
                    REG_LED_CYCLE:   led_cycle_reg   <= cfg_data;
                    REG_LED_BLINK:   led_blink_reg   <= cfg_data;
                    REG_HB_PERIOD:   hb_period_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            if (ctl.commit)
            begin
                k_reg <= '0;
                if (tail.fatal_hit)
                    fatal_store_reg <= tail.fatal_ch;
                if (tail.disp != '0)
                    hb_level_reg <= 1'b1;
                else if ((now_reg - last_toggle_reg) >= {16'd0, hb_period_reg})
                begin
                    // toggle the heartbeat LED once hb_period has passed and no offline channel has a group
                    last_toggle_reg <= now_reg;
                    hb_level_reg    <= ~hb_level_reg;
                end
            end
            if (out_fire && !out_last)
                k_reg <= k_reg + 4'd1;
        end
    end

    // Payload captured along the check; no reset needed
    always_ff @(posedge clk)
    begin
        if (ctl.eval)
            now_reg <= item.now;
        if (ctl.commit)
        begin
            trip_reg  <= trip;
            disp_reg  <= tail.disp[3:0];
            group_reg <= tail.best_group;
            oled_reg  <= 1'b0;
        end
        if (state_reg == S_CYC && div_done)
        begin
            phase_reg <= div_r;
            oled_reg  <= (div_r >= {16'd0, led_blink_reg});
        end
        if (state_reg == S_PH && div_done)
            oled_reg <= ~div_q[0];
    end

    // Results
    assign m_tvalid = (state_reg == S_OUT);
    assign out_fire = m_tvalid && m_tready;
    assign out_last = trip_reg || (k_reg == LAST_K);
    assign m_tlast  = out_last;
    assign m_tuser  = kind_w[k_reg];
    assign m_tdata  = {1'b0, trip_reg, fatal_store_reg, disp_reg,
                       hb_level_reg, oled_reg, k_reg};

endmodule

`default_nettype wire

// ===== design/lcm_chk.sv =====
// ----------------------------------------------------------------------------
// Liveness monitor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm_chk
    import lcm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // A request is never taken while a result is on offer
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request taken during result delivery");

    // No result in the cycle after a request
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result right after request");

    // A tripped check reports only the protect channel
    a_trip: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[14]) |-> (m_tlast && m_tdata[3:0] == 4'd0))
        else $error("protect trip not a single result");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind multi_channel_liveness_monitor lcm_chk u_lcm_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
